// ===== sv/hmv_pkg.sv =====
// ----------------------------------------------------------------------------
// hmv_pkg
// shared types, byte classes and defaults for the host/mask validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmv_pkg;

  localparam int DEF_MAX_HOST_LEN = 63;
  localparam int DEF_MAX_STARS    = 10;

  // byte class bits
  localparam logic [7:0] CLS_WILD  = 8'h01;
  localparam logic [7:0] CLS_HOST  = 8'h02;
  localparam logic [7:0] CLS_SEP   = 8'h04;
  localparam logic [7:0] CLS_ALPHA = 8'h80;

  // latched mode bit positions
  localparam int MODE_MASK = 0;
  localparam int MODE_NAME = 1;
  localparam int MODE_DOT  = 2;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [2:0] modes;  // dot, name, mask
  } beat_t;

  function automatic logic [7:0] byte_class(input logic [7:0] c);
    logic [7:0] cls;
    cls = 8'h00;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      cls = CLS_HOST | CLS_ALPHA;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = CLS_HOST;
    end else if (c == CH_DOT || c == CH_DASH) begin
      cls = CLS_SEP;
    end else if (c == CH_STAR || c == CH_QUEST) begin
      cls = CLS_WILD;
    end
    return cls;
  endfunction

endpackage

// ===== sv/hmv_in_stage.sv =====
// ----------------------------------------------------------------------------
// hmv_in_stage
// input register: holds one accepted beat for the scan stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmv_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          beat_valid,
  input  hmv_pkg::beat_t beat_in,
  output logic          s1_valid,
  output hmv_pkg::beat_t s1_beat
);
  import hmv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= beat_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (en && beat_valid) begin
      s1_beat <= beat_in;
    end
  end

endmodule

// ===== sv/hmv_scan.sv =====
// ----------------------------------------------------------------------------
// hmv_scan
// per-string scan state and the verdict for the final beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmv_scan #(
  parameter int MAX_HOST_LEN = hmv_pkg::DEF_MAX_HOST_LEN,
  parameter int MAX_STARS    = hmv_pkg::DEF_MAX_STARS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,     // a beat is consumed this cycle
  input  hmv_pkg::beat_t s1_beat,
  output logic           verdict
);
  import hmv_pkg::*;

  localparam int NS_W = $clog2(MAX_HOST_LEN + 2);
  localparam int ST_W = $clog2(MAX_STARS + 2);
  localparam logic [NS_W-1:0] NS_MAX = NS_W'(MAX_HOST_LEN);
  localparam logic [ST_W-1:0] ST_MAX = ST_W'(MAX_STARS);

  logic            in_string;
  logic            failed;
  logic            at_component_start;
  logic            last_inner_was_sep;
  logic [NS_W-1:0] nonstar_count;
  logic [ST_W-1:0] star_count;
  logic [7:0]      prev_byte;
  logic            seen_dot;
  logic [2:0]      latched_modes;

  // state as seen by this beat (fresh values on the first byte)
  logic [2:0]      modes_e;
  logic            failed_e, acs_e, lis_e, seen_dot_e;
  logic [NS_W-1:0] ns_e;
  logic [ST_W-1:0] st_e;
  logic [7:0]      prev_e;

  logic            failed_next, at_component_start_next, last_inner_was_sep_next;
  logic [NS_W-1:0] nonstar_count_next;
  logic [ST_W-1:0] star_count_next;
  logic            seen_dot_next;

  logic [7:0] cls, prev_cls;
  logic       wild_en, is_wild, is_sep, is_host, is_star, bad;
  logic       name_bad;

  always_comb begin
    modes_e    = in_string ? latched_modes : s1_beat.modes;
    failed_e   = in_string & failed;
    acs_e      = ~in_string | at_component_start;
    lis_e      = in_string & last_inner_was_sep;
    ns_e       = in_string ? nonstar_count : '0;
    st_e       = in_string ? star_count : '0;
    prev_e     = in_string ? prev_byte : 8'h00;
    seen_dot_e = in_string & seen_dot;

    cls      = byte_class(s1_beat.ch);
    prev_cls = byte_class(prev_e);
    wild_en  = modes_e[MODE_MASK];
    is_wild  = wild_en & ((cls & CLS_WILD) != 8'h00);
    is_sep   = (cls & CLS_SEP) != 8'h00;
    is_host  = (cls & CLS_HOST) != 8'h00;
    is_star  = wild_en & (s1_beat.ch == CH_STAR);

    star_count_next         = st_e;
    nonstar_count_next      = ns_e;
    last_inner_was_sep_next = lis_e;
    if (acs_e) begin
      bad = ~(is_host | is_wild);
      if (is_star) begin
        if (st_e <= ST_MAX) star_count_next = st_e + 1'b1;
      end else if (ns_e <= NS_MAX) begin
        nonstar_count_next = ns_e + 1'b1;
      end
      at_component_start_next = 1'b0;
    end else begin
      bad = ~(is_host | is_sep | is_wild);
      if (ns_e <= NS_MAX) nonstar_count_next = ns_e + 1'b1;
      last_inner_was_sep_next = is_sep;
      at_component_start_next = is_sep | is_wild;
    end
    failed_next   = failed_e | bad;
    seen_dot_next = seen_dot_e | (s1_beat.ch == CH_DOT);

    // name-like ending check on the last two bytes
    name_bad = 1'b0;
    if (modes_e[MODE_NAME]) begin
      if (modes_e[MODE_MASK]) begin
        if (s1_beat.ch != CH_STAR) begin
          if (s1_beat.ch != CH_QUEST && (cls & CLS_ALPHA) == 8'h00) name_bad = 1'b1;
          if ((prev_cls & (CLS_WILD | CLS_ALPHA)) == 8'h00) name_bad = 1'b1;
        end
      end else begin
        if ((cls & CLS_ALPHA) == 8'h00 || (prev_cls & CLS_ALPHA) == 8'h00) name_bad = 1'b1;
      end
    end

    verdict = ~failed_next & ~last_inner_was_sep_next &
              (nonstar_count_next <= NS_MAX) & (star_count_next <= ST_MAX) &
              ~name_bad & ~(modes_e[MODE_DOT] & ~seen_dot_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_string <= 1'b0;
    end else if (step) begin
      in_string <= ~s1_beat.last;
    end
  end

  // the rest is reloaded on the first byte of each string
  always_ff @(posedge clk) begin
    if (step) begin
      latched_modes      <= modes_e;
      failed             <= failed_next;
      at_component_start <= at_component_start_next;
      last_inner_was_sep <= last_inner_was_sep_next;
      nonstar_count      <= nonstar_count_next;
      star_count         <= star_count_next;
      prev_byte          <= s1_beat.ch;
      seen_dot           <= seen_dot_next;
    end
  end

endmodule

// ===== sv/hostname_mask_validator_core.sv =====
// a last byte is held in the input register, then its verdict in the result register
// throughput: one byte per cycle; the pipeline holds only while out_stall
//   keeps a finished verdict waiting in the output register
// reset: rst (synchronous, active high) empties both stages and ends any
//   partial string; in_stall is high during reset
// ----------------------------------------------------------------------------
// hostname_mask_validator_core
// streaming checker for host names and host masks, one byte per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hostname_mask_validator_core #(
  parameter int MAX_HOST_LEN = hmv_pkg::DEF_MAX_HOST_LEN,
  parameter int MAX_STARS    = hmv_pkg::DEF_MAX_STARS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic       mask_mode,
  input  logic       name_check,
  input  logic       dot_required,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       host_ok
);
  import hmv_pkg::*;

  // the whole pipe advances unless a verdict is waiting and stalled
  logic           en;
  beat_t          beat_in;
  logic           s1_valid;
  beat_t          s1_beat;
  logic           step;
  logic           verdict;

  assign en       = ~(out_valid & out_stall);
  assign in_stall = rst | ~en;

  assign beat_in.ch    = ch;
  assign beat_in.last  = last;
  assign beat_in.modes = {dot_required, name_check, mask_mode};

  // stage 1: input register
  hmv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .beat_valid (in_valid),
    .beat_in    (beat_in),
    .s1_valid   (s1_valid),
    .s1_beat    (s1_beat)
  );

  // stage 2: scan state update for the registered beat
  assign step = en & s1_valid;

  hmv_scan #(
    .MAX_HOST_LEN (MAX_HOST_LEN),
    .MAX_STARS    (MAX_STARS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .s1_beat (s1_beat),
    .verdict (verdict)
  );

  // result register: one verdict per string, on its last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid & s1_beat.last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_beat.last) begin
      host_ok <= verdict;
    end
  end

endmodule

// ===== sv/hmv_checker.sv =====
// ----------------------------------------------------------------------------
// hmv_checker
// port-level checks for the host/mask validator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmv_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       host_ok
);

  // a stalled verdict beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(host_ok))
    else $error("stalled verdict changed");

  // a fresh verdict follows an accepted last beat through the input and result registers
  a_verdict_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
    else $error("verdict without a last beat");

  // input only backs up behind a stalled verdict
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with output free");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict valid after reset");

endmodule

bind hostname_mask_validator_core hmv_checker u_hmv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .host_ok   (host_ok)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for hostname_mask_validator_core: host strings go in
// one byte per beat, an in-bench model of the checker predicts each verdict
// and a monitor compares every verdict beat against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hmv_pkg::*;

  localparam int HOST_LEN_LIMIT = DEF_MAX_HOST_LEN;
  localparam int STAR_LIMIT     = DEF_MAX_STARS;
  localparam int RANDOM_BYTES   = 100;      // per idling phase
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int RUN_LIMIT_NS   = 2000000;
  localparam int PRINT_LIMIT    = 40;

  // dut ports, every input known from time zero
  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] ch           = 8'h00;
  logic       last         = 1'b0;
  logic       mask_mode    = 1'b0;
  logic       name_check   = 1'b0;
  logic       dot_required = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       host_ok;

  // idle odds in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;

  // model state of the checker, mirrors one string in flight
  logic       mdl_in_string   = 1'b0;
  logic       mdl_failed      = 1'b0;
  logic       mdl_comp_start  = 1'b1;
  logic       mdl_tail_sep    = 1'b0;
  logic       mdl_seen_dot    = 1'b0;
  int         mdl_nonstars    = 0;
  int         mdl_stars       = 0;
  logic [7:0] mdl_prev        = 8'h00;
  logic [2:0] mdl_modes       = 3'b000;   // dot, name, mask

  // verdicts predicted but not yet seen on the output
  logic       pending_verdicts[$];
  logic       verdict_want;

  // text of the next string to send
  logic [7:0] host_text[$];

  hostname_mask_validator_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .last         (last),
    .mask_mode    (mask_mode),
    .name_check   (name_check),
    .dot_required (dot_required),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .host_ok      (host_ok)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_top: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("mismatch @%0t: %s", $time, what);
    end
  endtask

  // byte classes, written out independently of the package helper
  function automatic logic [7:0] char_kind(input logic [7:0] c);
    logic [7:0] kind;
    kind = 8'h00;
    if (c == CH_STAR || c == CH_QUEST) begin
      kind = CLS_WILD;
    end else if (c == CH_DOT || c == CH_DASH) begin
      kind = CLS_SEP;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      kind = CLS_HOST;
    end else if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A) begin
      // case fold covers both letter ranges
      kind = CLS_HOST | CLS_ALPHA;
    end
    return kind;
  endfunction

  // advance the model by one accepted byte, queue a verdict on the last one
  task automatic predict_host_byte(input logic [7:0] c, input logic l, input logic m,
                                   input logic n, input logic d);
    logic [7:0] kind;
    logic [7:0] prev_kind;
    logic [7:0] wild;
    logic       ok;
    // modes only count on the opening byte of a string
    if (!mdl_in_string) begin
      mdl_modes      = {d, n, m};
      mdl_failed     = 1'b0;
      mdl_comp_start = 1'b1;
      mdl_tail_sep   = 1'b0;
      mdl_nonstars   = 0;
      mdl_stars      = 0;
      mdl_prev       = 8'h00;
      mdl_seen_dot   = 1'b0;
    end
    kind = char_kind(c);
    wild = mdl_modes[MODE_MASK] ? CLS_WILD : 8'h00;
    if (mdl_comp_start) begin
      // opening byte of a component: alnum, or wildcard in mask mode
      if ((kind & (CLS_HOST | wild)) == 8'h00) mdl_failed = 1'b1;
      if (wild != 8'h00 && c == CH_STAR) begin
        if (mdl_stars <= STAR_LIMIT) mdl_stars++;
      end else if (mdl_nonstars <= HOST_LEN_LIMIT) begin
        mdl_nonstars++;
      end
      mdl_comp_start = 1'b0;
    end else begin
      if ((kind & (CLS_HOST | CLS_SEP | wild)) == 8'h00) mdl_failed = 1'b1;
      if (mdl_nonstars <= HOST_LEN_LIMIT) mdl_nonstars++;
      mdl_tail_sep = (kind & CLS_SEP) != 8'h00;
      // separator or wildcard closes the component
      if ((kind & (CLS_SEP | wild)) != 8'h00) mdl_comp_start = 1'b1;
    end
    if (c == CH_DOT) mdl_seen_dot = 1'b1;
    if (!l) begin
      mdl_prev      = c;
      mdl_in_string = 1'b1;
    end else begin
      ok = !mdl_failed && !mdl_tail_sep && mdl_nonstars <= HOST_LEN_LIMIT &&
           mdl_stars <= STAR_LIMIT;
      if (mdl_modes[MODE_NAME]) begin
        prev_kind = char_kind(mdl_prev);
        if (mdl_modes[MODE_MASK]) begin
          // a trailing star always passes the ending rule
          if (c != CH_STAR) begin
            if (c != CH_QUEST && (kind & CLS_ALPHA) == 8'h00) ok = 1'b0;
            if ((prev_kind & (CLS_WILD | CLS_ALPHA)) == 8'h00) ok = 1'b0;
          end
        end else if ((kind & CLS_ALPHA) == 8'h00 || (prev_kind & CLS_ALPHA) == 8'h00) begin
          ok = 1'b0;
        end
      end
      if (mdl_modes[MODE_DOT] && !mdl_seen_dot) ok = 1'b0;
      pending_verdicts.push_back(ok);
      mdl_in_string  = 1'b0;
      mdl_comp_start = 1'b1;
      mdl_tail_sep   = 1'b0;
      mdl_prev       = 8'h00;
    end
  endtask

  // one byte beat; valid stays high across back-to-back beats
  task automatic send_byte(input logic [7:0] c, input logic l, input logic m,
                           input logic n, input logic d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    ch           <= c;
    last         <= l;
    mask_mode    <= m;
    name_check   <= n;
    dot_required <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    predict_host_byte(c, l, m, n, d);
  endtask

  // send host_text as one string; optionally churn the mode bits after the
  // opening byte, which the block must ignore
  task automatic send_host(input logic m, input logic n, input logic d,
                           input bit churn_modes);
    logic mm;
    logic nn;
    logic dd;
    for (int i = 0; i < host_text.size(); i++) begin
      mm = m;
      nn = n;
      dd = d;
      if (i != 0 && churn_modes) begin
        mm = 1'($urandom_range(1));
        nn = 1'($urandom_range(1));
        dd = 1'($urandom_range(1));
      end
      send_byte(host_text[i], i == host_text.size() - 1, mm, nn, dd);
    end
    host_text.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) host_text.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? 8'h41 : 8'h61;
    return base + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_alnum();
    if ($urandom_range(3) == 0) return 8'h30 + 8'($urandom_range(9));
    return pick_letter();
  endfunction

  function automatic logic [7:0] pick_wild();
    return $urandom_range(1) ? CH_STAR : CH_QUEST;
  endfunction

  // well-formed-looking host: components joined by dots or dashes,
  // wildcards sprinkled in when masks are allowed
  task automatic build_host(input logic allow_wild);
    int comps;
    int inner;
    comps = $urandom_range(1, 4);
    for (int k = 0; k < comps; k++) begin
      if (k != 0) host_text.push_back($urandom_range(3) == 0 ? CH_DASH : CH_DOT);
      if (allow_wild && $urandom_range(4) == 0) host_text.push_back(pick_wild());
      else host_text.push_back(pick_alnum());
      inner = $urandom_range(0, 5);
      for (int j = 0; j < inner; j++) begin
        if (allow_wild && $urandom_range(9) == 0) host_text.push_back(pick_wild());
        else host_text.push_back(pick_alnum());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // hand-picked strings: field extremes, each ending rule, one-byte strings,
  // mode changes mid-string, bytes consumed after a failure
  task automatic test_directed_cases();
    add_text("a");      send_host(1'b0, 1'b1, 1'b0, 1'b0);  // lone byte, name rule sees 0x00
    add_text("z");      send_host(1'b0, 1'b0, 1'b0, 1'b0);
    add_text("Z9");     send_host(1'b0, 1'b0, 1'b0, 1'b0);
    host_text.push_back(8'h00);
    send_host(1'b1, 1'b1, 1'b1, 1'b0);                      // null byte
    host_text.push_back(8'hFF);
    send_host(1'b0, 1'b0, 1'b0, 1'b0);                      // top byte value
    add_text("A.b");    send_host(1'b0, 1'b0, 1'b1, 1'b0);  // one-byte tail after dot
    add_text("a.bc");   send_host(1'b1, 1'b1, 1'b1, 1'b1);  // every mode, churned later
    add_text("?*");     send_host(1'b1, 1'b1, 1'b0, 1'b0);  // wildcard-only mask
    add_text("a-");     send_host(1'b0, 1'b0, 1'b0, 1'b0);  // trailing separator
    add_text("a#bc");   send_host(1'b0, 1'b0, 1'b0, 1'b0);  // bad byte, rest still consumed
    // star refused on the opening byte, later mask bits must not rescue it
    host_text.push_back(CH_STAR);
    host_text.push_back(8'h62);
    send_byte(host_text[0], 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(host_text[1], 1'b1, 1'b1, 1'b0, 1'b0);
    host_text.delete();
  endtask

  // count of non-star bytes right at and around the length limit
  task automatic test_length_limit();
    int lens[4];
    lens = '{HOST_LEN_LIMIT - 1, HOST_LEN_LIMIT, HOST_LEN_LIMIT + 1, HOST_LEN_LIMIT + 2};
    foreach (lens[i]) begin
      for (int j = 0; j < lens[i]; j++) host_text.push_back(pick_letter());
      send_host(1'b0, 1'($urandom_range(1)), 1'b0, 1'b1);
    end
    // leading star is not counted toward the length
    host_text.push_back(CH_STAR);
    for (int j = 0; j < HOST_LEN_LIMIT; j++) host_text.push_back(pick_letter());
    send_host(1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  // component-leading stars at and around the star limit
  task automatic test_star_limit();
    for (int k = STAR_LIMIT - 1; k <= STAR_LIMIT + 2; k++) begin
      for (int j = 0; j < k; j++) begin
        host_text.push_back(CH_STAR);
        host_text.push_back(CH_DOT);
      end
      add_text("ab");
      send_host(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
    end
  endtask

  // mostly plausible hosts and masks, some mutated, some pure noise
  task automatic test_random_hosts(input int byte_budget);
    int stop_at;
    int pick;
    int n;
    logic m;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      m = 1'($urandom_range(1));
      if (pick < 60) begin
        build_host(m);
        // occasional corruption: stray byte or dangling separator
        n = $urandom_range(9);
        if (n == 0) host_text[$urandom_range(host_text.size() - 1)] = 8'($urandom_range(255));
        else if (n == 1) host_text.push_back($urandom_range(1) ? CH_DOT : CH_DASH);
      end else if (pick < 72) begin
        n = $urandom_range(1, 4);
        for (int j = 0; j < n; j++) host_text.push_back(8'($urandom_range(255)));
      end else if (pick < 87) begin
        // aim at the two-byte ending rule
        build_host(m);
        for (int j = 0; j < 2; j++) begin
          case ($urandom_range(3))
            0: host_text.push_back(pick_wild());
            1: host_text.push_back(8'h30 + 8'($urandom_range(9)));
            default: host_text.push_back(pick_letter());
          endcase
        end
      end else begin
        // one or two byte strings from the interesting classes
        n = $urandom_range(1, 2);
        for (int j = 0; j < n; j++) begin
          case ($urandom_range(3))
            0: host_text.push_back(pick_wild());
            1: host_text.push_back($urandom_range(1) ? CH_DOT : CH_DASH);
            default: host_text.push_back(pick_alnum());
          endcase
        end
      end
      send_host(m, 1'($urandom_range(1)), $urandom_range(3) == 0, 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // verdict monitor: one beat per accepted output
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict beat with no string pending");
      end else begin
        verdict_want = pending_verdicts.pop_front();
        if (host_ok !== verdict_want) begin
          report_mismatch($sformatf("host_ok got %b want %b", host_ok, verdict_want));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // light sender gaps, heavy receiver stalls
    send_idle_pct = 14;
    recv_idle_pct = 53;
    test_directed_cases();
    test_length_limit();
    test_star_limit();
    test_random_hosts(RANDOM_BYTES);

    // swap the pressure
    send_idle_pct = 53;
    recv_idle_pct = 14;
    test_random_hosts(RANDOM_BYTES);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_hosts(RANDOM_BYTES);

    in_valid <= 1'b0;
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    end

    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
